// ----- hdl/keyed_hash_cache_linear_probe_macros.svh -----
// ----------------------------------------------------------------------------
// keyed_hash_cache_linear_probe_macros
// assertion shorthands shared by the cache modules
// ----------------------------------------------------------------------------
`ifndef KEYED_HASH_CACHE_LINEAR_PROBE_MACROS_SVH
`define KEYED_HASH_CACHE_LINEAR_PROBE_MACROS_SVH

// clocked check, masked while reset is asserted
`define KHC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked check that also holds during reset
`define KHC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/khc_pkg.sv -----
// ----------------------------------------------------------------------------
// khc_pkg
// shared types and constants of the keyed hash cache
// ----------------------------------------------------------------------------
`default_nettype none

package khc_pkg;

    // result slot field width
    localparam int SLOT_W = 15;

    // hash multipliers
    localparam logic [31:0] MUL_CP = 32'd2654435761;
    localparam logic [31:0] MUL_FH = 32'd2246822519;

    // operation codes
    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // input transfer payload
    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] code_point;
        logic [31:0] font_id;
        logic [15:0] value_in;
    } khc_in_t;

    // result transfer payload
    typedef struct packed {
        logic              hit;
        logic [15:0]       value_out;
        logic [SLOT_W-1:0] slot;
    } khc_out_t;

    // one table entry as kept in memory
    typedef struct packed {
        logic        occupied;
        logic [63:0] key;
        logic [15:0] value;
    } khc_entry_t;

    // controller states
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_HASH,
        S_HOME,
        S_PRB_FIRST,
        S_PROBE,
        S_WRITE,
        S_CLEAR,
        S_DONE
    } khc_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic hash_en;
        logic home_clr;
        logic home_run;
        logic prb_first;
        logic prb_eval;
        logic mem_rd;
        logic mem_wr;
        logic wr_clear;
        logic clr_step;
        logic res_load;
    } khc_ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic [1:0] new_cmd;
        logic       is_insert;
        logic       home_done;
        logic       prb_decide;
        logic       clr_last;
        logic       out_free;
    } khc_sts_t;

endpackage

`default_nettype wire

// ----- hdl/khc_ram.sv -----
// ----------------------------------------------------------------------------
// khc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module khc_ram #(
    parameter int WIDTH = 81,
    parameter int DEPTH = 32768,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write and registered read
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hdl/khc_ctrl.sv -----
// ----------------------------------------------------------------------------
// khc_ctrl
// sequencer for hash, home slot reduction, probing, writes and clear sweeps
// ----------------------------------------------------------------------------
`default_nettype none

module khc_ctrl import khc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  khc_sts_t sts,
    output khc_ctl_t ctl
);

`include "keyed_hash_cache_linear_probe_macros.svh"

    khc_state_t state_reg;
    khc_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT: begin
                if (sts.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    unique case (sts.new_cmd)
                        CMD_LOOKUP: state_next = S_HASH;
                        CMD_INSERT: state_next = S_HASH;
                        CMD_CLEAR:  state_next = S_CLEAR;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_HASH: begin
                state_next = S_HOME;
            end
            S_HOME: begin
                if (sts.home_done) state_next = S_PRB_FIRST;
            end
            S_PRB_FIRST: begin
                state_next = S_PROBE;
            end
            S_PROBE: begin
                if (sts.prb_decide) begin
                    state_next = sts.is_insert ? S_WRITE : S_DONE;
                end
            end
            S_WRITE: begin
                state_next = S_DONE;
            end
            S_CLEAR: begin
                if (sts.clr_last) state_next = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) state_next = S_IDLE;
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    // command outputs
    always_comb begin
        ctl     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            S_INIT: begin
                ctl.mem_wr   = 1'b1;
                ctl.wr_clear = 1'b1;
                ctl.clr_step = 1'b1;
            end
            S_IDLE: begin
                s_ready     = 1'b1;
                ctl.load_in = s_valid;
            end
            S_HASH: begin
                ctl.hash_en  = 1'b1;
                ctl.home_clr = 1'b1;
            end
            S_HOME: begin
                ctl.home_run = 1'b1;
            end
            S_PRB_FIRST: begin
                ctl.prb_first = 1'b1;
                ctl.mem_rd    = 1'b1;
            end
            S_PROBE: begin
                ctl.prb_eval = 1'b1;
                ctl.mem_rd   = !sts.prb_decide;
            end
            S_WRITE: begin
                ctl.mem_wr = 1'b1;
            end
            S_CLEAR: begin
                ctl.mem_wr   = 1'b1;
                ctl.wr_clear = 1'b1;
                ctl.clr_step = 1'b1;
            end
            S_DONE: begin
                ctl.res_load = sts.out_free;
            end
            default: begin
                ctl = '0;
            end
        endcase
    end

    // assertions
    `KHC_ASSERT(a_accept_leaves_idle, aclk, aresetn, (s_valid && s_ready) |=> (state_reg != S_IDLE), "accepted transfer left controller idle")
    `KHC_ASSERT(a_result_then_idle, aclk, aresetn, ctl.res_load |=> (state_reg == S_IDLE), "result loaded without return to idle")
    `KHC_ASSERT(a_ready_only_idle, aclk, aresetn, s_ready |-> (state_reg == S_IDLE), "input ready outside idle")
    `KHC_ASSERT_ALWAYS(a_reset_to_init, aclk, !aresetn |=> (state_reg == S_INIT), "reset did not return controller to init")

endmodule

`default_nettype wire

// ----- hdl/khc_dp.sv -----
// ----------------------------------------------------------------------------
// khc_dp
// hash, home slot reduction, probe compare, entry memory and result register
// ----------------------------------------------------------------------------
`default_nettype none

module khc_dp import khc_pkg::*; #(
    parameter int TABLE_DEPTH = 32768,
    parameter int MAX_PROBE   = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  khc_in_t  s_item,
    output logic     m_valid,
    input  logic     m_ready,
    output khc_out_t m_item,
    input  khc_ctl_t ctl,
    output khc_sts_t sts
);

`include "keyed_hash_cache_linear_probe_macros.svh"

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int IDX_W  = (MAX_PROBE > 1) ? $clog2(MAX_PROBE) : 1;
    localparam bit DEPTH_POW2 = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(MAX_PROBE - 1);

    khc_in_t            in_reg;
    logic [31:0]        h_reg;
    logic [31:0]        prod_cp;
    logic [31:0]        prod_fh;
    logic [ADDR_W-1:0]  home_reg;
    logic               home_done;
    logic [ADDR_W-1:0]  chk_addr_reg;
    logic [IDX_W-1:0]   chk_idx_reg;
    logic [ADDR_W-1:0]  nxt_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  clr_addr_reg;
    logic [ADDR_W-1:0]  at_reg;
    logic               same_reg;
    logic [15:0]        fval_reg;
    logic [63:0]        key;
    khc_entry_t         rd_entry;
    khc_entry_t         wr_entry;
    logic               slot_empty;
    logic               slot_match;
    logic               prb_last;
    logic               decide;
    logic               m_valid_reg;
    khc_out_t           m_item_reg;
    khc_out_t           res;

    // input capture
    always_ff @(posedge aclk) begin
        if (ctl.load_in) begin
            in_reg <= s_item;
        end
    end

    assign key = {in_reg.font_id, in_reg.code_point};

    // hash: two low-half products, registered
    assign prod_cp = in_reg.code_point * MUL_CP;
    assign prod_fh = in_reg.font_id * MUL_FH;

    always_ff @(posedge aclk) begin
        if (ctl.hash_en) begin
            h_reg <= prod_cp ^ prod_fh;
        end
    end

    // home slot: low bits, or a three-step reciprocal remainder for other depths
    generate
        if (DEPTH_POW2) begin : g_home_mask
            always_ff @(posedge aclk) begin
                if (ctl.home_run) begin
                    home_reg <= h_reg[ADDR_W-1:0];
                end
            end
            assign home_done = 1'b1;
        end else begin : g_home_rem
            // quotient estimate is exact or one short, so one subtract corrects it
            localparam logic [31:0]     RECIP   = 32'((64'd1 << 32) / TABLE_DEPTH);
            localparam logic [ADDR_W:0] DEPTH_W = (ADDR_W + 1)'(TABLE_DEPTH);
            logic [1:0]      step_reg;
            logic [63:0]     qprod;
            logic [ADDR_W:0] quot_reg;
            logic [ADDR_W:0] rem_reg;
            logic [ADDR_W:0] fix_reg;

            assign qprod = {32'd0, h_reg} * {32'd0, RECIP};

            always_ff @(posedge aclk) begin
                if (ctl.home_clr) begin
                    step_reg <= '0;
                end else if (ctl.home_run) begin
                    step_reg <= step_reg + 2'd1;
                    quot_reg <= qprod[32 +: (ADDR_W + 1)];
                    rem_reg  <= h_reg[ADDR_W:0] - quot_reg * DEPTH_W;
                    fix_reg  <= (rem_reg >= DEPTH_W) ? (rem_reg - DEPTH_W) : rem_reg;
                end
            end
            assign home_reg  = fix_reg[ADDR_W-1:0];
            assign home_done = (step_reg == 2'd2);
        end
    endgenerate

    // probe address walk with wrap
    assign nxt_addr = (chk_addr_reg == LAST_ADDR) ? '0 : (chk_addr_reg + 1'b1);
    assign rd_addr  = ctl.prb_first ? home_reg : nxt_addr;

    always_ff @(posedge aclk) begin
        if (ctl.mem_rd) begin
            chk_addr_reg <= rd_addr;
            chk_idx_reg  <= ctl.prb_first ? '0 : (chk_idx_reg + 1'b1);
        end
    end

    // slot compare
    assign slot_empty = !rd_entry.occupied;
    assign slot_match = rd_entry.occupied && (rd_entry.key == key);
    assign prb_last   = (chk_idx_reg == LAST_IDX);
    assign decide     = slot_empty || slot_match || prb_last;

    // probe outcome
    always_ff @(posedge aclk) begin
        if (ctl.prb_eval && decide) begin
            at_reg   <= (slot_empty || slot_match) ? chk_addr_reg : home_reg;
            same_reg <= slot_match;
            fval_reg <= rd_entry.value;
        end
    end

    // clear sweep counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (ctl.clr_step) begin
            clr_addr_reg <= (clr_addr_reg == LAST_ADDR) ? '0 : (clr_addr_reg + 1'b1);
        end
    end

    // memory write side
    always_comb begin
        if (ctl.wr_clear) begin
            wr_addr  = clr_addr_reg;
            wr_entry = '0;
        end else begin
            wr_addr           = at_reg;
            wr_entry.occupied = 1'b1;
            wr_entry.key      = key;
            wr_entry.value    = in_reg.value_in;
        end
    end

    khc_ram #(
        .WIDTH ($bits(khc_entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (ctl.mem_wr),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (ctl.mem_rd),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    // result build
    always_comb begin
        res = '0;
        unique case (in_reg.cmd)
            CMD_LOOKUP: begin
                if (same_reg) begin
                    res.hit       = 1'b1;
                    res.value_out = fval_reg;
                    res.slot      = SLOT_W'(at_reg);
                end
            end
            CMD_INSERT: begin
                res.hit       = same_reg;
                res.value_out = in_reg.value_in;
                res.slot      = SLOT_W'(at_reg);
            end
            default: begin
                res = '0;
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.res_load) begin
            m_item_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // status back to the controller
    assign sts.new_cmd    = s_item.cmd;
    assign sts.is_insert  = (in_reg.cmd == CMD_INSERT);
    assign sts.home_done  = home_done;
    assign sts.prb_decide = decide;
    assign sts.clr_last   = (clr_addr_reg == LAST_ADDR);
    assign sts.out_free   = !m_valid_reg || m_ready;

    // assertions
    `KHC_ASSERT(a_home_in_range, aclk, aresetn, ctl.prb_first |-> (home_reg < TABLE_DEPTH), "home slot beyond table depth")
    `KHC_ASSERT(a_probe_in_range, aclk, aresetn, ctl.prb_eval |-> (chk_addr_reg < TABLE_DEPTH), "probe slot beyond table depth")
    `KHC_ASSERT(a_full_window_home, aclk, aresetn, (ctl.prb_eval && prb_last && !slot_empty && !slot_match) |=> (at_reg == $past(home_reg)), "full probe window did not pick home slot")

endmodule

`default_nettype wire

// ----- hdl/keyed_hash_cache_linear_probe.sv -----
// Lookup and insert each make 1 to MAX_PROBE slot reads from the entry ram; an insert then
// writes the chosen slot. The entry ram gives one read a cycle while probing.
// A non-power-of-two TABLE_DEPTH adds the steps of the reciprocal home slot remainder.
// One item is in flight; input ready returns once its result is registered.
// Reset and every clear run a sweep of the whole entry ram, with input ready low.
// ----------------------------------------------------------------------------
// keyed_hash_cache_linear_probe
// open-addressing cache of (code point, font handle) keys with linear probing
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_hash_cache_linear_probe import khc_pkg::*; #(
    parameter int TABLE_DEPTH = 32768,
    parameter int MAX_PROBE   = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  khc_in_t  s_item,
    output logic     m_valid,
    input  logic     m_ready,
    output khc_out_t m_item
);

    khc_ctl_t ctl;
    khc_sts_t sts;

    // sequencer
    khc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    // datapath with entry memory
    khc_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_PROBE   (MAX_PROBE)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .ctl     (ctl),
        .sts     (sts)
    );

endmodule

`default_nettype wire
